### rtl/ncdf_pkg.sv
// shared constants, coefficient tables and pipeline types for the normal cdf block
package ncdf_pkg;

   localparam int IN_FRAC_BITS_DEF  = 16;
   localparam int OUT_FRAC_BITS_DEF = 16;

   localparam int U_W         = 24;  // argument width
   localparam int ARG_FRAC    = 26;  // fraction bits of |y|, y*y and |y|-2
   localparam int ACC_FRAC    = 30;  // fraction bits of the horner accumulator
   localparam int LIMIT_EXP   = 33;  // accumulator clamps at +-2^33
   localparam int ACC_W       = LIMIT_EXP + 2;
   localparam int X_W         = 30;  // horner operand, covers -1.0 .. 4.0
   localparam int YS_W        = ARG_FRAC;  // |y| in the small branch
   localparam int YQ_W        = 29;  // |y| up to 6.0
   localparam int SPLIT       = 18;  // accumulator split for the partial products
   localparam int PROD_W      = 64;
   localparam int NUM_CELLS   = 14;
   localparam int SMALL_STEPS = 8;

   localparam logic signed [ACC_W-1:0] SMALL_COEF [SMALL_STEPS+1] = '{
      35'sd134023, -35'sd1154492, 35'sd5582142, -35'sd20614009, 35'sd63408788,
      -35'sd163175204, 35'sd342687852, -35'sd571147980, 35'sd856722023
   };

   localparam logic signed [ACC_W-1:0] BIG_COEF [NUM_CELLS+1] = '{
      -35'sd48593, 35'sd163777, -35'sd20979, -35'sd726821, 35'sd1493150,
      -35'sd853218, -35'sd2184265, 35'sd7032785, -35'sd11336164, 35'sd12488098,
      -35'sd9963737, 35'sd5748362, -35'sd2299170, 35'sd574785, 35'sd1073673811
   };

   typedef enum logic [1:0] {
      SPEC_NONE,
      SPEC_HALF,
      SPEC_LOW,
      SPEC_HIGH
   } spec_type;

   typedef struct packed {
      spec_type                  spec;
      logic                      is_small;
      logic                      neg;
      logic [YS_W-1:0]           yq;
      logic signed [X_W-1:0]     x;
      logic signed [ACC_W-1:0]   acc;
   } token_type;

   typedef struct packed {
      logic      valid;
      token_type tok;
   } beat_type;

endpackage

### rtl/ncdf_req_if.sv
// argument channel: valid, ready and the signed argument
interface ncdf_req_if
   import ncdf_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic signed [U_W-1:0] u_value;

   modport source (output valid, output u_value, input ready);
   modport sink (input valid, input u_value, output ready);
endinterface

### rtl/ncdf_rsp_if.sv
// result channel: valid, ready and the cdf value
interface ncdf_rsp_if #(
   parameter int WIDTH = 17
) ();
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] cdf_value;

   modport source (output valid, output cdf_value, input ready);
   modport sink (input valid, input cdf_value, output ready);
endinterface

### rtl/normal_cdf_poly_approx.sv
// top level of the fixed-point standard normal cdf pipeline
//
//   channel   dir   handshake       payload
//   req_chan  in    valid / ready   u_value   signed, IN_FRAC_BITS fraction bits
//   rsp_chan  out   valid / ready   cdf_value unsigned, OUT_FRAC_BITS fraction bits
//
// one transaction per cycle sustained while rsp_ready stays high; two front stages,
// fourteen horner cells of two stages each, one output register
// synchronous active-high reset empties every stage, no clearing pass
// each stage holds only while it is full and the stage after it holds, so
// bubbles close up and new arguments enter while a result waits on rsp_ready
module normal_cdf_poly_approx
   import ncdf_pkg::*;
#(
   parameter int IN_FRAC_BITS  = IN_FRAC_BITS_DEF,
   parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ncdf_req_if.sink   req_chan,
   ncdf_rsp_if.source rsp_chan
);

   beat_type chain_beat [NUM_CELLS+1];
   logic     chain_hold [NUM_CELLS+1];
   logic     front_hold;

   assign req_chan.ready = !front_hold;

   ncdf_front #(
      .IN_FRAC_BITS (IN_FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_u      (req_chan.u_value),
      .up_hold   (front_hold),
      .out_beat  (chain_beat[0]),
      .down_hold (chain_hold[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      ncdf_cell #(
         .IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_beat   (chain_beat[i]),
         .up_hold   (chain_hold[i]),
         .out_beat  (chain_beat[i+1]),
         .down_hold (chain_hold[i+1])
      );
   end

   ncdf_back #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_beat   (chain_beat[NUM_CELLS]),
      .up_hold   (chain_hold[NUM_CELLS]),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_data  (rsp_chan.cdf_value)
   );

endmodule

### rtl/ncdf_front.sv
// front stages: magnitude, special cases, branch select, y squared and start value
module ncdf_front
   import ncdf_pkg::*;
#(
   parameter int IN_FRAC_BITS = IN_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [U_W-1:0] in_u,
   output logic                  up_hold,
   output beat_type              out_beat,
   input  logic                  down_hold
);

   localparam int SH     = ARG_FRAC - 1 - IN_FRAC_BITS;
   localparam int WIDE_W = U_W + SH + YQ_W;
   localparam logic [WIDE_W-1:0]   SAT_LIM  = WIDE_W'(12) << IN_FRAC_BITS;
   localparam logic [2*YS_W-1:0]   SQ_HALF  = (2*YS_W)'(1) << (ARG_FRAC - 1);
   localparam logic [X_W-1:0]      TWO_ARG  = X_W'(2) << ARG_FRAC;

   logic              s1_valid_ff;
   spec_type          s1_spec_ff, s1_spec_in;
   logic              s1_neg_ff, s1_neg_in;
   logic              s1_small_ff, s1_small_in;
   logic [YQ_W-1:0]   s1_yq_ff, s1_yq_in;
   logic              s1_hold, s2_hold;

   logic [U_W-1:0]    mag;
   logic [WIDE_W-1:0] wide;

   logic [2*YS_W-1:0] sq, sq_r;
   logic [YS_W-1:0]   w;
   beat_type          beat_ff;
   token_type         tok_in;

   assign s2_hold = beat_ff.valid && down_hold;
   assign s1_hold = s1_valid_ff && s2_hold;
   assign up_hold = s1_hold;
   assign out_beat = beat_ff;

   always_comb begin
      mag = in_u[U_W-1] ? (U_W'(0) - unsigned'(in_u)) : unsigned'(in_u);
      wide = WIDE_W'(mag) << SH;
      s1_neg_in = in_u[U_W-1];
      s1_yq_in = wide[YQ_W-1:0];
      s1_small_in = (wide[YQ_W-1:ARG_FRAC] == '0);
      if (in_u == '0) begin
         s1_spec_in = SPEC_HALF;
      end else if (WIDE_W'(mag) > SAT_LIM) begin
         s1_spec_in = in_u[U_W-1] ? SPEC_LOW : SPEC_HIGH;
      end else begin
         s1_spec_in = SPEC_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!s1_hold) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!s1_hold) begin
         s1_spec_ff  <= s1_spec_in;
         s1_neg_ff   <= s1_neg_in;
         s1_small_ff <= s1_small_in;
         s1_yq_ff    <= s1_yq_in;
      end
   end

   // y squared rounds to nearest; the value is never negative
   always_comb begin
      sq = s1_yq_ff[YS_W-1:0] * s1_yq_ff[YS_W-1:0];
      sq_r = sq + SQ_HALF;
      w = sq_r[2*YS_W-1:ARG_FRAC];
      tok_in.spec = s1_spec_ff;
      tok_in.is_small = s1_small_ff;
      tok_in.neg = s1_neg_ff;
      tok_in.yq = s1_yq_ff[YS_W-1:0];
      if (s1_small_ff) begin
         tok_in.x = X_W'(w);
         tok_in.acc = SMALL_COEF[0];
      end else begin
         tok_in.x = X_W'(s1_yq_ff) - TWO_ARG;
         tok_in.acc = BIG_COEF[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (!s2_hold) begin
         beat_ff.valid <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!s2_hold) begin
         beat_ff.tok <= tok_in;
      end
   end

endmodule

### rtl/ncdf_cell.sv
// one horner cell: split multiply, then round, add coefficient and clamp
module ncdf_cell
   import ncdf_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  beat_type in_beat,
   output logic     up_hold,
   output beat_type out_beat,
   input  logic     down_hold
);

   localparam int HI_W  = ACC_W - SPLIT;
   localparam int PH_W  = HI_W + X_W;
   localparam int PL_W  = SPLIT + 1 + X_W;
   localparam int RND_W = PROD_W - ARG_FRAC + 1;
   localparam int SUM_W = RND_W + 1;
   localparam bit IS_FINAL = (IDX == SMALL_STEPS);
   localparam bit IS_IDLE  = (IDX > SMALL_STEPS);
   localparam logic signed [ACC_W-1:0] BIG_C = BIG_COEF[IDX+1];
   localparam logic signed [ACC_W-1:0] SMALL_C =
      (IDX < SMALL_STEPS) ? SMALL_COEF[(IDX < SMALL_STEPS) ? IDX + 1 : 0] : '0;
   localparam logic signed [PROD_W-1:0] RND_STEP = PROD_W'(1) << (ARG_FRAC - 1);
   localparam logic signed [PROD_W-1:0] RND_FIN  = PROD_W'(1) << (ARG_FRAC - 2);
   localparam logic signed [SUM_W-1:0]  SUM_HI   = SUM_W'(1) << LIMIT_EXP;
   localparam logic signed [SUM_W-1:0]  SUM_LO   = -SUM_HI;

   logic                     a_valid_ff;
   token_type                a_tok_ff;
   logic signed [PH_W-1:0]   a_pp_hi_ff, a_pp_hi_in;
   logic signed [PL_W-1:0]   a_pp_lo_ff, a_pp_lo_in;
   logic signed [X_W-1:0]    op;
   logic signed [HI_W-1:0]   hi;
   logic signed [SPLIT:0]    lo;
   logic                     a_hold, b_hold;

   beat_type                 beat_ff;
   token_type                b_tok_in;
   logic signed [PROD_W-1:0] prod, t, sh;
   logic signed [RND_W-1:0]  rnd;
   logic signed [ACC_W-1:0]  coef;
   logic signed [SUM_W-1:0]  sum, clamped;
   logic                     is_final;

   assign b_hold = beat_ff.valid && down_hold;
   assign a_hold = a_valid_ff && b_hold;
   assign up_hold = a_hold;
   assign out_beat = beat_ff;

   // the last small-branch cell multiplies by |y| instead of y squared
   always_comb begin
      if (in_beat.tok.is_small && IS_FINAL) begin
         op = X_W'(in_beat.tok.yq);
      end else begin
         op = in_beat.tok.x;
      end
      hi = in_beat.tok.acc[ACC_W-1:SPLIT];
      lo = {1'b0, in_beat.tok.acc[SPLIT-1:0]};
      a_pp_hi_in = hi * op;
      a_pp_lo_in = lo * op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (!a_hold) begin
         a_valid_ff <= in_beat.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!a_hold) begin
         a_tok_ff   <= in_beat.tok;
         a_pp_hi_ff <= a_pp_hi_in;
         a_pp_lo_ff <= a_pp_lo_in;
      end
   end

   // rounding ties away from zero: add half, less one when negative
   always_comb begin
      is_final = a_tok_ff.is_small && IS_FINAL;
      prod = (PROD_W'(a_pp_hi_ff) <<< SPLIT) + PROD_W'(a_pp_lo_ff);
      t = prod + (is_final ? RND_FIN : RND_STEP) - PROD_W'(prod[PROD_W-1]);
      sh = is_final ? (t >>> (ARG_FRAC - 1)) : (t >>> ARG_FRAC);
      rnd = sh[RND_W-1:0];
      coef = a_tok_ff.is_small ? SMALL_C : BIG_C;
      sum = SUM_W'(rnd) + SUM_W'(coef);
      if (sum > SUM_HI) begin
         clamped = SUM_HI;
      end else if (sum < SUM_LO) begin
         clamped = SUM_LO;
      end else begin
         clamped = sum;
      end
      b_tok_in = a_tok_ff;
      if (!(a_tok_ff.is_small && IS_IDLE)) begin
         b_tok_in.acc = clamped[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (!b_hold) begin
         beat_ff.valid <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!b_hold) begin
         beat_ff.tok <= b_tok_in;
      end
   end

endmodule

### rtl/ncdf_back.sv
// output stage: (1 +- z) / 2, rounding, clamp, special cases and result register
module ncdf_back
   import ncdf_pkg::*;
#(
   parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  beat_type               in_beat,
   output logic                   up_hold,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OUT_FRAC_BITS:0] rsp_data
);

   localparam int OUT_W = OUT_FRAC_BITS + 1;
   localparam int S_W   = ACC_W + 2;
   localparam int SH_N  = ACC_FRAC + 1 - OUT_FRAC_BITS;
   localparam logic signed [S_W-1:0] ONE_S  = S_W'(1) << ACC_FRAC;
   localparam logic signed [S_W-1:0] RND_H  = S_W'(1) << (SH_N - 1);
   localparam logic signed [S_W-1:0] FULL_S = S_W'(1) << OUT_FRAC_BITS;
   localparam logic [OUT_W-1:0] FULL_V = OUT_W'(1) << OUT_FRAC_BITS;
   localparam logic [OUT_W-1:0] HALF_V = OUT_W'(1) << (OUT_FRAC_BITS - 1);

   logic                  valid_ff;
   logic [OUT_W-1:0]      data_ff, data_in;
   logic                  hold;
   logic signed [S_W-1:0] s, t, r;
   logic [OUT_W-1:0]      poly_v;

   assign hold = valid_ff && !rsp_ready;
   assign up_hold = hold;
   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

   always_comb begin
      if (in_beat.tok.neg) begin
         s = ONE_S - S_W'(in_beat.tok.acc);
      end else begin
         s = ONE_S + S_W'(in_beat.tok.acc);
      end
      t = s + RND_H - S_W'(s[S_W-1]);
      r = t >>> SH_N;
      if (r[S_W-1]) begin
         poly_v = '0;
      end else if (r > FULL_S) begin
         poly_v = FULL_V;
      end else begin
         poly_v = r[OUT_W-1:0];
      end
      // empty stages carry an unknown code, so fall back to the polynomial value
      unique case (in_beat.tok.spec)
         SPEC_NONE: data_in = poly_v;
         SPEC_HALF: data_in = HALF_V;
         SPEC_LOW:  data_in = '0;
         SPEC_HIGH: data_in = FULL_V;
         default:   data_in = poly_v;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!hold) begin
         valid_ff <= in_beat.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         data_ff <= data_in;
      end
   end

endmodule

### rtl/ncdf_checker.sv
// port-level checks on the normal cdf pipeline, bound to the top level
module ncdf_checker
   import ncdf_pkg::*;
#(
   parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [OUT_FRAC_BITS:0] rsp_cdf_value
);

   localparam int PEND_W = 6;
   localparam logic [OUT_FRAC_BITS:0] FULL_V = (OUT_FRAC_BITS + 1)'(1) << OUT_FRAC_BITS;

   logic [PEND_W-1:0] pend_ff, pend_in;
   logic              req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;
   assign pend_in = pend_ff + PEND_W'(req_xfer) - PEND_W'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_cdf_value))
      else $error("result changed while stalled");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cdf_value <= FULL_V)
      else $error("cdf value above one");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> pend_ff != '0)
      else $error("result without an accepted argument");

endmodule

bind normal_cdf_poly_approx ncdf_checker #(
   .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_ncdf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_cdf_value (rsp_chan.cdf_value)
);
